[rtl/utf8hn_pkg.sv]
`timescale 1ns / 1ps

package utf8hn_pkg;

  // Most bytes that one input item can release.
  localparam int unsigned MaxOut = 4;
  // Default depth of the output queue; it must be at least twice MaxOut.
  // Nine entries let a ready receiver drain every group without stalling input.
  localparam int unsigned QueueDepth = 9;
  localparam int unsigned NumGlyphs = 28;

  typedef logic [20:0] cp_t;

  // A group of result bytes released by one input item, lowest index first.
  typedef struct packed {
    logic [2:0]                n;
    logic [MaxOut-1:0][7:0]    bytes;
  } group_t;

  // Sequence length announced by a lead byte.
  typedef enum logic [2:0] {
    LenBad = 3'd0,
    Len1   = 3'd1,
    Len2   = 3'd2,
    Len3   = 3'd3,
    Len4   = 3'd4
  } lead_len_e;

  // Zero-width code points that are dropped.
  localparam cp_t CpZwSpace  = 21'h0200B;
  localparam cp_t CpZwNonJn  = 21'h0200C;
  localparam cp_t CpZwJoiner = 21'h0200D;
  localparam cp_t CpWordJn   = 21'h02060;
  localparam cp_t CpBom      = 21'h0FEFF;

  // Greek and Cyrillic letters that look like ASCII letters.
  localparam logic [10:0] GlyphCp [NumGlyphs] = '{
    11'h391, 11'h392, 11'h395, 11'h397, 11'h399, 11'h39A, 11'h39C, 11'h39D,
    11'h39F, 11'h3A1, 11'h3A4, 11'h3A5, 11'h396,
    11'h410, 11'h412, 11'h421, 11'h415, 11'h41D, 11'h41A, 11'h41C, 11'h41E,
    11'h420, 11'h422,
    11'h430, 11'h441, 11'h435, 11'h43E, 11'h440
  };

  localparam logic [7:0] GlyphAscii [NumGlyphs] = '{
    8'h41, 8'h42, 8'h45, 8'h48, 8'h49, 8'h4B, 8'h4D, 8'h4E, 8'h4F, 8'h50,
    8'h54, 8'h59, 8'h5A,
    8'h41, 8'h42, 8'h43, 8'h45, 8'h48, 8'h4B, 8'h4D, 8'h4F, 8'h50, 8'h54,
    8'h61, 8'h63, 8'h65, 8'h6F, 8'h70
  };

  // Classify a byte met where a lead byte is expected.
  function automatic lead_len_e lead_len(input logic [7:0] b);
    lead_len_e len;
    if (!b[7]) begin
      len = Len1;
    end else if (b[7:5] == 3'b110) begin
      len = Len2;
    end else if (b[7:4] == 4'b1110) begin
      len = Len3;
    end else if (b[7:3] == 5'b11110) begin
      len = Len4;
    end else begin
      len = LenBad;
    end
    return len;
  endfunction

  // Drop, map or re-encode one code point in its shortest form.
  function automatic group_t encode_cp(input cp_t cp);
    group_t     g;
    logic       hit;
    logic [7:0] asc;
    g   = '0;
    hit = 1'b0;
    asc = '0;
    for (int k = 0; k < NumGlyphs; k++) begin
      if (cp == {10'd0, GlyphCp[k]}) begin
        hit = 1'b1;
        asc = GlyphAscii[k];
      end
    end
    if (cp == CpZwSpace || cp == CpZwNonJn || cp == CpZwJoiner ||
        cp == CpWordJn || cp == CpBom) begin
      g.n = 3'd0;
    end else if (hit) begin
      g.n        = 3'd1;
      g.bytes[0] = asc;
    end else if (cp < 21'h80) begin
      g.n        = 3'd1;
      g.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      g.n        = 3'd2;
      g.bytes[0] = {3'b110, cp[10:6]};
      g.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      g.n        = 3'd3;
      g.bytes[0] = {4'b1110, cp[15:12]};
      g.bytes[1] = {2'b10, cp[11:6]};
      g.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      g.n        = 3'd4;
      g.bytes[0] = {5'b11110, cp[20:18]};
      g.bytes[1] = {2'b10, cp[17:12]};
      g.bytes[2] = {2'b10, cp[11:6]};
      g.bytes[3] = {2'b10, cp[5:0]};
    end
    return g;
  endfunction

endpackage

[rtl/utf8hn_core.sv]
`timescale 1ns / 1ps

module utf8hn_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output utf8hn_pkg::group_t  group_o
);

  logic [1:0]             cnt_q, cnt_d;
  utf8hn_pkg::lead_len_e  need_q, need_d;
  logic [7:0]             pend_q [3];
  logic                   pend_we;
  logic [1:0]             pend_idx;
  utf8hn_pkg::group_t     grp_q, grp_d;

  utf8hn_pkg::lead_len_e  len_in;
  logic [2:0]             total;
  utf8hn_pkg::cp_t        cp_full, cp_pair;
  utf8hn_pkg::group_t     enc_full, enc_pair;

  // Code point of a complete sequence, and of a two-byte tail after a cut lead.
  always_comb begin
    unique case (need_q)
      utf8hn_pkg::Len2: cp_full = {10'd0, pend_q[0][4:0], byte_i[5:0]};
      utf8hn_pkg::Len3: cp_full = {5'd0, pend_q[0][3:0], pend_q[1][5:0], byte_i[5:0]};
      utf8hn_pkg::Len4: cp_full = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0],
                                   byte_i[5:0]};
      default:          cp_full = '0;
    endcase
    cp_pair = {10'd0, pend_q[1][4:0], byte_i[5:0]};
  end

  assign enc_full = utf8hn_pkg::encode_cp(cp_full);
  assign enc_pair = utf8hn_pkg::encode_cp(cp_pair);
  assign len_in   = utf8hn_pkg::lead_len(byte_i);
  assign total    = {1'b0, cnt_q} + 3'd1;

  // Either hold the byte in the open sequence or release a group of bytes.
  always_comb begin
    cnt_d    = cnt_q;
    need_d   = need_q;
    pend_we  = 1'b0;
    pend_idx = cnt_q;
    grp_d    = '0;
    if (accept_i) begin
      if (cnt_q == 2'd0) begin
        if ((len_in == utf8hn_pkg::Len2 || len_in == utf8hn_pkg::Len3 ||
             len_in == utf8hn_pkg::Len4) && !last_i) begin
          cnt_d    = 2'd1;
          need_d   = len_in;
          pend_we  = 1'b1;
        end else begin
          grp_d.n        = 3'd1;
          grp_d.bytes[0] = byte_i;
        end
      end else if (total < 3'(need_q) && !last_i) begin
        cnt_d   = total[1:0];
        pend_we = 1'b1;
      end else begin
        cnt_d  = 2'd0;
        need_d = utf8hn_pkg::LenBad;
        if (total == 3'(need_q)) begin
          grp_d = enc_full;
        end else if (total == 3'd2) begin
          // Cut short after the lead: both bytes pass through.
          grp_d.n        = 3'd2;
          grp_d.bytes[0] = pend_q[0];
          grp_d.bytes[1] = byte_i;
        end else if (utf8hn_pkg::lead_len(pend_q[1]) == utf8hn_pkg::Len2) begin
          // Cut four-byte lead followed by a whole two-byte sequence.
          grp_d.n        = enc_pair.n + 3'd1;
          grp_d.bytes[0] = pend_q[0];
          grp_d.bytes[1] = enc_pair.bytes[0];
          grp_d.bytes[2] = enc_pair.bytes[1];
        end else begin
          grp_d.n        = 3'd3;
          grp_d.bytes[0] = pend_q[0];
          grp_d.bytes[1] = pend_q[1];
          grp_d.bytes[2] = byte_i;
        end
      end
    end
  end

  // Sequence control state and the result group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      need_q <= utf8hn_pkg::LenBad;
      grp_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      need_q <= need_d;
      grp_q  <= grp_d;
    end
  end

  // Held bytes carry no reset.
  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      case (pend_idx)
        2'd0:    pend_q[0] <= byte_i;
        2'd1:    pend_q[1] <= byte_i;
        default: pend_q[2] <= byte_i;
      endcase
    end
  end

  assign group_o = grp_q;

endmodule

[rtl/utf8hn_queue.sv]
`timescale 1ns / 1ps

module utf8hn_queue #(
  parameter int unsigned Depth = utf8hn_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utf8hn_pkg::group_t  group_i,
  output logic                room_o,
  output logic                tvalid_o,
  input  logic                tready_i,
  output logic [7:0]          tdata_o,
  output logic                tlast_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned OffW = $clog2(utf8hn_pkg::MaxOut);

  logic [CntW-1:0] cnt_q, cnt_d, base, grp_n, off;
  logic [CntW:0]   fill;
  logic [7:0]      data_q [Depth];
  logic [7:0]      data_d [Depth];
  logic            last_q [Depth];
  logic            last_d [Depth];
  logic            pop;

  assign pop   = tvalid_o & tready_i;
  assign grp_n = CntW'(group_i.n);
  assign base  = cnt_q - CntW'(pop);
  assign cnt_d = base + grp_n;

  // Room for a full group once the group in flight has landed.
  assign fill   = {1'b0, cnt_q} + {1'b0, grp_n};
  assign room_o = fill <= (CntW + 1)'(Depth - utf8hn_pkg::MaxOut);

  // Shift toward the head on a pop, then append the new group after the tail.
  always_comb begin
    for (int i = 0; i < Depth - 1; i++) begin
      data_d[i] = pop ? data_q[i+1] : data_q[i];
      last_d[i] = pop ? last_q[i+1] : last_q[i];
    end
    data_d[Depth-1] = data_q[Depth-1];
    last_d[Depth-1] = last_q[Depth-1];
    for (int i = 0; i < Depth; i++) begin
      off = CntW'(i) - base;
      if (CntW'(i) >= base && off < grp_n) begin
        data_d[i] = group_i.bytes[off[OffW-1:0]];
        last_d[i] = (off == grp_n - CntW'(1));
      end
    end
  end

  // Fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Queue entries.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign tvalid_o = (cnt_q != '0);
  assign tdata_o  = data_q[0];
  assign tlast_o  = last_q[0];

endmodule

[rtl/utf8_homoglyph_normalizer.sv]
`timescale 1ns / 1ps

// Channel   Direction  tdata          tlast
// s_axis    in         in_byte[7:0]   in_last
// m_axis    out        out_byte[7:0]  run_last
//
// One input item can be taken in every cycle while s_axis_tready is high. Its
// result group (zero to four bytes) is registered at the accepting edge and
// enters the output queue at the next edge.
// Reset clears the open sequence and empties the queue; no clearing pass.
// s_axis_tready drops while queued bytes plus the group in flight exceed
// QueueDepth minus four; with a ready receiver and the default QueueDepth this never happens.

module utf8_homoglyph_normalizer #(
  parameter int unsigned QueueDepth = utf8hn_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte[7:0]
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte[7:0]
  output logic       m_axis_tlast
);

  utf8hn_pkg::group_t group;
  logic               accept;

  assign accept = s_axis_tvalid & s_axis_tready;

  // Sequence assembly and normalization.
  utf8hn_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .group_o  (group)
  );

  // Output queue.
  utf8hn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .group_i  (group),
    .room_o   (s_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast)
  );

endmodule

[rtl/utf8hn_checker.sv]
`timescale 1ns / 1ps

module utf8hn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic        s_acc, m_acc;
  logic [15:0] owed_q;

  assign s_acc = s_axis_tvalid & s_axis_tready;
  assign m_acc = m_axis_tvalid & m_axis_tready;

  // Items taken in minus items sent out; never negative, since a result
  // group is never longer than the bytes that caused it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      owed_q <= owed_q + 16'(s_acc) - 16'(m_acc);
    end
  end

  // A waiting input item holds its value.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
    else $error("input item changed while waiting");

  // A stalled output item holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // No output item without an earlier input item to account for it.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc |-> owed_q != 16'd0)
    else $error("more output items than input items");

  // The queue is empty once reset has been held.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // An idle block with an empty queue stays empty.
  a_stay_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !s_acc && !$past(s_acc) |=> !m_axis_tvalid)
    else $error("output appeared without input");

endmodule

bind utf8_homoglyph_normalizer utf8hn_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
